/* rtl/core/tcba_pkg.sv */
`default_nettype none

package tcba_pkg;

  localparam int TCBA_BIN_COUNT = 16384;
  localparam int TCBA_LOAD_BITS = 32;
  localparam int BIN_W          = 14;
  localparam int NOISE_W        = 24;
  localparam int THR_W          = 16;
  localparam int BALL_W         = 40;
  localparam int OUT_LOAD_W     = 32;
  localparam int RED_CNT_W      = 4;
  localparam int RED_SUB_W      = 28;

  typedef enum logic {
    CFG_DECISION_MODE  = 1'b0,
    CFG_LOAD_THRESHOLD = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    MODE_TWO_CHOICE = 2'd0,
    MODE_BOUNDED    = 2'd1,
    MODE_MYOPIC     = 2'd2,
    MODE_NOISY      = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_READ,
    ST_DECIDE,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic [BIN_W-1:0]          first_bin;
    logic [BIN_W-1:0]          second_bin;
    logic                      coin;
    logic signed [NOISE_W-1:0] noise_first;
    logic signed [NOISE_W-1:0] noise_second;
  } in_t;

  typedef struct packed {
    logic [BIN_W-1:0]      chosen_bin;
    logic [OUT_LOAD_W-1:0] chosen_load;
    logic [OUT_LOAD_W-1:0] max_load;
    logic [BALL_W-1:0]     ball_count;
  } out_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic reduce_step;
    logic decide;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic red_done;
  } dp_status_t;

  function automatic bit is_pow2(int n);
    return (n & (n - 1)) == 0;
  endfunction

  // iterations of the index reduction unit, zero when no reduction is iterated
  function automatic int red_steps(int n);
    if (n >= (1 << BIN_W) || is_pow2(n)) begin
      return 0;
    end
    return BIN_W + 1 - $clog2(n);
  endfunction

  function automatic logic [RED_SUB_W-1:0] red_sub_init(int n);
    int s;
    s = red_steps(n);
    if (s == 0) begin
      return '0;
    end
    return RED_SUB_W'(n) << (s - 1);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/tcba_ram.sv */
`default_nettype none

module tcba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

/* rtl/core/tcba_dp.sv */
`default_nettype none

module tcba_dp
  import tcba_pkg::*;
#(
  parameter int BIN_COUNT = TCBA_BIN_COUNT,
  parameter int LOAD_BITS = TCBA_LOAD_BITS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_index_i,
  input  wire logic [THR_W-1:0] cfg_wdata_i,
  input  wire in_t              item_i,
  input  wire dp_cmd_t          cmd_i,
  output dp_status_t            status_o,
  output out_t                  result_o,
  output logic                  done_o
);

  localparam int IDX_W = $clog2(BIN_COUNT);
  localparam int CW    = (LOAD_BITS > THR_W) ? LOAD_BITS : THR_W;
  localparam int EW    = CW + 2;
  localparam bit NEEDS_MASK = is_pow2(BIN_COUNT) && (BIN_COUNT < (1 << BIN_W));
  localparam logic [BIN_W-1:0] IDX_MASK = NEEDS_MASK ? BIN_W'(BIN_COUNT - 1) : '1;
  localparam logic [RED_CNT_W-1:0] RED_STEPS = RED_CNT_W'(red_steps(BIN_COUNT));
  localparam logic [RED_SUB_W-1:0] RED_SUB_INIT = red_sub_init(BIN_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BIN_COUNT - 1);

  logic [BIN_W-1:0]     r1_q, r1_d, r2_q, r2_d;
  logic                 coin_q;
  logic [NOISE_W-1:0]   noise1_q, noise2_q;
  logic [RED_CNT_W-1:0] red_cnt_q, red_cnt_d;
  logic [RED_SUB_W-1:0] sub_q, sub_d;
  logic [IDX_W-1:0]     clr_cnt_q;
  logic                 pick_q, pick_d;
  logic [LOAD_BITS-1:0] peak_q, peak_d;
  logic [BALL_W-1:0]    balls_q, balls_d;
  out_t                 result_q;
  logic                 done_q;
  mode_e                mode_q;
  logic [THR_W-1:0]     thr_q;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [LOAD_BITS-1:0] ram_wdata;
  logic [LOAD_BITS-1:0] l1, l2;

  logic [LOAD_BITS-1:0] gap;
  logic                 near, first_smaller;
  logic signed [EW-1:0] s1, s2, est1, est2;
  logic                 inc1, inc2;
  logic [BIN_W-1:0]     chosen;
  logic [LOAD_BITS-1:0] sel_load, new_load;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TWO_CHOICE;
      thr_q  <= THR_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_DECISION_MODE:  mode_q <= mode_e'(cfg_wdata_i[1:0]);
        CFG_LOAD_THRESHOLD: thr_q  <= cfg_wdata_i;
        default:            mode_q <= mode_q;
      endcase
    end
  end

  // index reduction, one restoring step per cycle
  always_comb begin
    r1_d      = r1_q;
    r2_d      = r2_q;
    red_cnt_d = red_cnt_q;
    sub_d     = sub_q;
    if (cmd_i.accept) begin
      r1_d      = item_i.first_bin & IDX_MASK;
      r2_d      = item_i.second_bin & IDX_MASK;
      red_cnt_d = RED_STEPS;
      sub_d     = RED_SUB_INIT;
    end else if (cmd_i.reduce_step) begin
      if (RED_SUB_W'(r1_q) >= sub_q) begin
        r1_d = r1_q - BIN_W'(sub_q);
      end
      if (RED_SUB_W'(r2_q) >= sub_q) begin
        r2_d = r2_q - BIN_W'(sub_q);
      end
      red_cnt_d = red_cnt_q - RED_CNT_W'(1);
      sub_d     = sub_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_cnt_q <= '0;
      clr_cnt_q <= '0;
    end else begin
      red_cnt_q <= red_cnt_d;
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q  <= r1_d;
    r2_q  <= r2_d;
    sub_q <= sub_d;
    if (cmd_i.accept) begin
      coin_q   <= item_i.coin;
      noise1_q <= item_i.noise_first;
      noise2_q <= item_i.noise_second;
    end
  end

  assign status_o.clear_done = cmd_i.clear && (clr_cnt_q == LAST_IDX);
  assign status_o.red_done   = (red_cnt_q == '0);

  // load table
  assign ram_we    = cmd_i.clear | cmd_i.update;
  assign ram_waddr = cmd_i.clear ? clr_cnt_q : IDX_W'(chosen);
  assign ram_wdata = cmd_i.clear ? '0 : new_load;

  tcba_ram #(
    .WIDTH (LOAD_BITS),
    .DEPTH (BIN_COUNT)
  ) u_load_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (IDX_W'(r1_q)),
    .raddr_b_i (IDX_W'(r2_q)),
    .rdata_a_o (l1),
    .rdata_b_o (l2)
  );

  // decision
  always_comb begin
    gap           = (l1 >= l2) ? (l1 - l2) : (l2 - l1);
    near          = CW'(gap) <= CW'(thr_q);
    first_smaller = l1 <= l2;
    s1   = $signed(EW'(l1)) + EW'($signed(noise1_q[NOISE_W-1:8]));
    s2   = $signed(EW'(l2)) + EW'($signed(noise2_q[NOISE_W-1:8]));
    inc1 = s1[EW-1] & (|noise1_q[7:0]);
    inc2 = s2[EW-1] & (|noise2_q[7:0]);
    est1 = s1 + $signed(EW'({1'b0, inc1}));
    est2 = s2 + $signed(EW'({1'b0, inc2}));
    case (mode_q)
      MODE_BOUNDED: pick_d = near ? !first_smaller : first_smaller;
      MODE_MYOPIC:  pick_d = near ? coin_q : first_smaller;
      MODE_NOISY:   pick_d = est1 <= est2;
      default:      pick_d = first_smaller;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      pick_q <= pick_d;
    end
  end

  // update
  always_comb begin
    chosen   = pick_q ? r1_q : r2_q;
    sel_load = pick_q ? l1 : l2;
    new_load = (sel_load == '1) ? sel_load : sel_load + LOAD_BITS'(1);
    peak_d   = (new_load > peak_q) ? new_load : peak_q;
    balls_d  = (balls_q == '1) ? balls_q : balls_q + BALL_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q  <= '0;
      balls_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.update;
      if (cmd_i.update) begin
        peak_q  <= peak_d;
        balls_q <= balls_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      result_q.chosen_bin  <= chosen;
      result_q.chosen_load <= OUT_LOAD_W'(new_load);
      result_q.max_load    <= OUT_LOAD_W'(peak_d);
      result_q.ball_count  <= balls_d;
    end
  end

  assign result_o = result_q;
  assign done_o   = done_q;

`ifndef NO_ASSERTIONS
  a_done_has_ball: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (result_q.ball_count != '0))
    else $error("result transfer with zero ball count");
  a_update_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> (red_cnt_q == '0))
    else $error("update before index reduction finished");
  a_peak_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> (peak_q >= $past(new_load)))
    else $error("peak load below chosen load");
`endif

endmodule

`default_nettype wire

/* rtl/core/tcba_ctrl.sv */
`default_nettype none

module tcba_ctrl
  import tcba_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o,
  output logic            busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (status_i.clear_done) state_d = ST_IDLE;
      ST_IDLE:   if (start_i) state_d = ST_REDUCE;
      ST_REDUCE: if (status_i.red_done) state_d = ST_READ;
      ST_READ:   state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.clear       = (state_q == ST_CLEAR);
    cmd_o.accept      = (state_q == ST_IDLE) && start_i;
    cmd_o.reduce_step = (state_q == ST_REDUCE) && !status_i.red_done;
    cmd_o.decide      = (state_q == ST_DECIDE);
    cmd_o.update      = (state_q == ST_UPDATE);
    busy_o            = (state_q != ST_IDLE);
  end

`ifndef NO_ASSERTIONS
  a_accept_to_reduce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == ST_REDUCE))
    else $error("accepted transfer did not start reduction");
  a_update_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |=> (state_q == ST_IDLE) && !busy_o)
    else $error("controller not idle after update");
  a_decide_then_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.decide |=> cmd_o.update)
    else $error("decision not followed by update");
`endif

endmodule

`default_nettype wire

/* rtl/core/two_choice_bin_allocator.sv */
// an accepted item takes S index reduction steps, then the read, decide and update states
// the controller walks reduce, read, decide and update before it returns to idle,
// so a new item is accepted only after the previous one has finished
// S is 0 when BIN_COUNT is a power of two or at least 16384, else 15 - clog2(BIN_COUNT)
// reset: asynchronous active low; then a clearing pass over all BIN_COUNT bins with busy high
// results show on done_o for one cycle; the receiver cannot stall
`default_nettype none

module two_choice_bin_allocator
  import tcba_pkg::*;
#(
  parameter int BIN_COUNT = TCBA_BIN_COUNT,
  parameter int LOAD_BITS = TCBA_LOAD_BITS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire in_t              item_i,
  output logic                  done_o,
  output out_t                  result_o,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_index_i,
  input  wire logic [THR_W-1:0] cfg_wdata_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  tcba_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  tcba_dp #(
    .BIN_COUNT (BIN_COUNT),
    .LOAD_BITS (LOAD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (result_o),
    .done_o      (done_o)
  );

endmodule

`default_nettype wire
